@@ sv/eahp_pkg.sv @@
package eahp_pkg;

  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned SampleBitsW  = 5;
  localparam int unsigned CountW       = 22;
  localparam int unsigned WeightW      = 13;
  localparam int unsigned ProdW        = CountW + WeightW;
  localparam int unsigned SumW         = 43;
  localparam int unsigned PixW         = 30;
  localparam int unsigned AvgW         = 13;
  localparam int unsigned QuadsW       = 20;
  localparam int unsigned IdxW         = 7;
  localparam int unsigned OutDataW     = 48;

  localparam logic [4:0] SampleBitsReset = 5'd10;
  localparam logic [7:0] MarkerByte      = 8'h55;
  localparam logic [7:0] LinearBins      = 8'd128;
  localparam logic [7:0] CheckEntry      = 8'd137;
  localparam logic [7:0] MinEntries      = 8'd144;
  localparam int unsigned PipeBits       = 13;
  localparam int unsigned LogShiftBase   = 17;

  // One unit of work handed from the parser to the accumulator.
  typedef struct packed {
    logic                 acc;
    logic                 emit;
    logic                 summary;
    logic                 ok_front;
    logic [IdxW-1:0]      idx;
    logic [CountW-1:0]    c;
    logic [WeightW-1:0]   w;
  } cmd_t;

  // Bytes per entry, clamped to the range four to eight.
  function automatic logic [3:0] entry_bytes(input logic [SampleBitsW-1:0] sb);
    logic [3:0] s;
    s = sb[4:1];
    if (s < 4'd4) s = 4'd4;
    if (s > 4'd8) s = 4'd8;
    return s;
  endfunction

  // Weight of log bin li (0 to 8): (3 << 13) >> (17 - li).
  function automatic logic [WeightW-1:0] log_weight(input logic [3:0] li);
    logic [15:0] base;
    logic [4:0]  sh;
    base = 16'(3) << PipeBits;
    sh   = 5'(LogShiftBase) - {1'b0, li};
    return WeightW'(base >> sh);
  endfunction

endpackage

@@ sv/eahp_front.sv @@
module eahp_front
  import eahp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [SampleBitsW-1:0] cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tlast,
  input  logic                   q_full,
  output logic                   q_push,
  output cmd_t                   q_data
);

  logic [SampleBitsW-1:0] sample_bits_r;
  logic [2:0]             pos_r, pos_nxt;
  logic [7:0]             ent_r, ent_nxt;
  logic [7:0]             held_r [3];
  logic [QuadsW-1:0]      second_r, second_nxt;
  logic                   failed_r, failed_nxt;

  logic                   accept;
  logic [3:0]             step;
  logic [CountW-1:0]      c;
  logic [QuadsW-1:0]      rep;
  logic                   bin_byte;
  logic                   wrap;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign step      = entry_bytes(sample_bits_r);

  assign c = {held_r[0], 14'd0} + {8'd0, held_r[1], 6'd0} + {16'd0, held_r[2][7:2]};
  assign rep = {held_r[0], 12'd0} + {8'd0, held_r[1], 4'd0} + {16'd0, in_tdata[7:4]};
  assign bin_byte = (pos_r == 3'd3) && (ent_r < CheckEntry);
  assign wrap = ({1'b0, pos_r} + 4'd1) >= step;

  always_comb begin
    failed_nxt = failed_r;
    second_nxt = second_r;
    if ((pos_r == 3'd2) && (ent_r == CheckEntry) && (rep != second_r)) failed_nxt = 1'b1;
    if (bin_byte && (in_tdata != MarkerByte)) failed_nxt = 1'b1;
    if (bin_byte && (ent_r == 8'd1)) second_nxt = c[CountW-1:2];
    if (wrap) begin
      pos_nxt = 3'd0;
      ent_nxt = (ent_r < MinEntries) ? ent_r + 8'd1 : ent_r;
    end else begin
      pos_nxt = pos_r + 3'd1;
      ent_nxt = ent_r;
    end
  end

  always_comb begin
    q_data.acc      = bin_byte && (ent_r != 8'd0);
    q_data.emit     = bin_byte && (ent_r < LinearBins) && !in_tlast;
    q_data.summary  = in_tlast;
    q_data.ok_front = !failed_nxt && (ent_nxt >= MinEntries);
    q_data.idx      = ent_r[IdxW-1:0];
    q_data.c        = c;
    if (ent_r < LinearBins) begin
      q_data.w = {ent_r[IdxW-1:0], 6'b100000};
    end else begin
      q_data.w = log_weight(4'(ent_r - LinearBins));
    end
    q_push = accept && (bin_byte || in_tlast);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_bits_r <= SampleBitsReset;
      pos_r         <= 3'd0;
      ent_r         <= 8'd0;
      second_r      <= '0;
      failed_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) sample_bits_r <= cfg_wr_data;
      if (accept) begin
        if (in_tlast) begin
          pos_r    <= 3'd0;
          ent_r    <= 8'd0;
          second_r <= '0;
          failed_r <= 1'b0;
        end else begin
          pos_r    <= pos_nxt;
          ent_r    <= ent_nxt;
          second_r <= second_nxt;
          failed_r <= failed_nxt;
        end
      end
    end
  end

  // The first three bytes of each entry are always written before they are read.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        if (pos_r == 3'(k)) held_r[k] <= in_tdata;
      end
    end
  end

endmodule

@@ sv/eahp_queue.sv @@
module eahp_queue
  import eahp_pkg::*;
#(
  parameter int unsigned WIDTH = $bits(cmd_t),
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CntW'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ sv/eahp_back.sv @@
module eahp_back
  import eahp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  cmd_t                q_data,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tuser
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_DIV, S_OUT} state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [ProdW-1:0]    prod_r;
  logic [SumW-1:0]     sum_r, sum_nxt;
  logic [PixW-1:0]     count_r, count_nxt;
  logic [SumW-1:0]     dvd_r;
  logic [PixW-1:0]     dvs_r;
  logic [PixW-1:0]     rem_r, rem_nxt;
  logic [AvgW-1:0]     quo_r, quo_nxt;
  logic [5:0]          div_cnt_r;
  logic [PixW:0]       rem_sh;
  logic                qbit;
  logic [OutDataW-1:0] out_data_r;
  logic                out_kind_r;

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (cmd_r.acc) begin
      sum_nxt   = sum_r + SumW'(prod_r);
      count_nxt = count_r + PixW'(cmd_r.c);
    end
    // One restoring step: the remainder always stays below the divisor.
    rem_sh  = {rem_r, dvd_r[SumW-1]};
    qbit    = rem_sh >= {1'b0, dvs_r};
    rem_nxt = qbit ? PixW'(rem_sh - {1'b0, dvs_r}) : rem_sh[PixW-1:0];
    quo_nxt = {quo_r[AvgW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      sum_r      <= '0;
      count_r    <= '0;
      out_kind_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_data;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= cmd_r.c * cmd_r.w;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (cmd_r.summary) begin
            sum_r   <= '0;
            count_r <= '0;
            if (cmd_r.ok_front && (count_nxt != '0)) begin
              dvd_r     <= sum_nxt;
              dvs_r     <= count_nxt;
              rem_r     <= '0;
              quo_r     <= '0;
              div_cnt_r <= '0;
              state_r   <= S_DIV;
            end else begin
              out_kind_r <= 1'b1;
              out_data_r <= '0;
              state_r    <= S_OUT;
            end
          end else begin
            sum_r   <= sum_nxt;
            count_r <= count_nxt;
            if (cmd_r.emit) begin
              out_kind_r <= 1'b0;
              out_data_r <= OutDataW'({cmd_r.c[CountW-1:2], cmd_r.idx});
              state_r    <= S_OUT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          rem_r     <= rem_nxt;
          quo_r     <= quo_nxt;
          dvd_r     <= {dvd_r[SumW-2:0], 1'b0};
          div_cnt_r <= div_cnt_r + 6'd1;
          if (div_cnt_r == 6'(SumW - 1)) begin
            out_kind_r <= 1'b1;
            out_data_r <= OutDataW'({1'b1, quo_nxt, {(QuadsW + IdxW){1'b0}}});
            state_r    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/embedded_ae_histogram_parser.sv @@
// Exposure histogram parser for the sensor's embedded-data region.
// Input: one byte per word on in_tdata, in_tlast on the final byte of a frame.
// Output: one word per linear bin (out_tuser low) carrying its index and count
// in quads, and one end-of-frame summary word (out_tuser high) carrying the
// valid flag and the weighted average level.
// cfg_wr_en/cfg_wr_data set the sensor bit depth; write it only while idle.
// The parser takes one byte per cycle whenever its four-deep work queue has
// room. Each entry makes at most one queue item, and a frame's last byte makes
// the summary item. The accumulator pops an item only from idle and takes it
// through three steps (pop, multiply, add) before a bin word is registered in
// out_data_r. A valid summary then runs a 43-step restoring divider, one
// quotient bit per cycle. While a result word waits on out_tready the
// accumulator holds, the queue fills and in_tready falls.
// Reset sets the bit depth to ten and clears all frame state; after each
// summary the frame state is cleared for the next frame.
module embedded_ae_histogram_parser
  import eahp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [SampleBitsW-1:0] cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [6:0] bin_index, [26:7] bin_quads, [39:27] average, [40] valid_res, rest zero
  output logic [OutDataW-1:0]    out_tdata,
  output logic                   out_tuser   // [0] kind
);

  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_in, q_out;

  eahp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  eahp_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  eahp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("work item pushed into a full queue");

  a_no_pop_while_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !q_pop)
    else $error("queue popped while a result word is pending");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid directly after reset");

endmodule
